### rtl/sha512_pkg.sv
// Shared constants and round functions for the SHA-512 stream hasher.
package sha512_pkg;

   localparam int unsigned WordW  = 64;
   localparam int unsigned NumCv  = 8;
   localparam int unsigned NumRnd = 80;

   typedef logic [WordW-1:0] word_type;

   function automatic word_type ror(input word_type x, input int unsigned n);
      ror = (x >> n) | (x << (WordW - n));
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = ror(x, 28) ^ ror(x, 34) ^ ror(x, 39);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = ror(x, 14) ^ ror(x, 18) ^ ror(x, 41);
   endfunction

   function automatic word_type ssig0(input word_type x);
      ssig0 = ror(x, 1) ^ ror(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type ssig1(input word_type x);
      ssig1 = ror(x, 19) ^ ror(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type init_value(input logic [2:0] idx);
      case (idx)
         3'd0:    init_value = 64'h6a09e667f3bcc908;
         3'd1:    init_value = 64'hbb67ae8584caa73b;
         3'd2:    init_value = 64'h3c6ef372fe94f82b;
         3'd3:    init_value = 64'ha54ff53a5f1d36f1;
         3'd4:    init_value = 64'h510e527fade682d1;
         3'd5:    init_value = 64'h9b05688c2b3e6c1f;
         3'd6:    init_value = 64'h1f83d9abfb41bd6b;
         default: init_value = 64'h5be0cd19137e2179;
      endcase
   endfunction

   function automatic word_type round_k(input logic [6:0] t);
      case (t)
         7'd0:  round_k = 64'h428a2f98d728ae22;  7'd1:  round_k = 64'h7137449123ef65cd;
         7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;  7'd3:  round_k = 64'he9b5dba58189dbbc;
         7'd4:  round_k = 64'h3956c25bf348b538;  7'd5:  round_k = 64'h59f111f1b605d019;
         7'd6:  round_k = 64'h923f82a4af194f9b;  7'd7:  round_k = 64'hab1c5ed5da6d8118;
         7'd8:  round_k = 64'hd807aa98a3030242;  7'd9:  round_k = 64'h12835b0145706fbe;
         7'd10: round_k = 64'h243185be4ee4b28c;  7'd11: round_k = 64'h550c7dc3d5ffb4e2;
         7'd12: round_k = 64'h72be5d74f27b896f;  7'd13: round_k = 64'h80deb1fe3b1696b1;
         7'd14: round_k = 64'h9bdc06a725c71235;  7'd15: round_k = 64'hc19bf174cf692694;
         7'd16: round_k = 64'he49b69c19ef14ad2;  7'd17: round_k = 64'hefbe4786384f25e3;
         7'd18: round_k = 64'h0fc19dc68b8cd5b5;  7'd19: round_k = 64'h240ca1cc77ac9c65;
         7'd20: round_k = 64'h2de92c6f592b0275;  7'd21: round_k = 64'h4a7484aa6ea6e483;
         7'd22: round_k = 64'h5cb0a9dcbd41fbd4;  7'd23: round_k = 64'h76f988da831153b5;
         7'd24: round_k = 64'h983e5152ee66dfab;  7'd25: round_k = 64'ha831c66d2db43210;
         7'd26: round_k = 64'hb00327c898fb213f;  7'd27: round_k = 64'hbf597fc7beef0ee4;
         7'd28: round_k = 64'hc6e00bf33da88fc2;  7'd29: round_k = 64'hd5a79147930aa725;
         7'd30: round_k = 64'h06ca6351e003826f;  7'd31: round_k = 64'h142929670a0e6e70;
         7'd32: round_k = 64'h27b70a8546d22ffc;  7'd33: round_k = 64'h2e1b21385c26c926;
         7'd34: round_k = 64'h4d2c6dfc5ac42aed;  7'd35: round_k = 64'h53380d139d95b3df;
         7'd36: round_k = 64'h650a73548baf63de;  7'd37: round_k = 64'h766a0abb3c77b2a8;
         7'd38: round_k = 64'h81c2c92e47edaee6;  7'd39: round_k = 64'h92722c851482353b;
         7'd40: round_k = 64'ha2bfe8a14cf10364;  7'd41: round_k = 64'ha81a664bbc423001;
         7'd42: round_k = 64'hc24b8b70d0f89791;  7'd43: round_k = 64'hc76c51a30654be30;
         7'd44: round_k = 64'hd192e819d6ef5218;  7'd45: round_k = 64'hd69906245565a910;
         7'd46: round_k = 64'hf40e35855771202a;  7'd47: round_k = 64'h106aa07032bbd1b8;
         7'd48: round_k = 64'h19a4c116b8d2d0c8;  7'd49: round_k = 64'h1e376c085141ab53;
         7'd50: round_k = 64'h2748774cdf8eeb99;  7'd51: round_k = 64'h34b0bcb5e19b48a8;
         7'd52: round_k = 64'h391c0cb3c5c95a63;  7'd53: round_k = 64'h4ed8aa4ae3418acb;
         7'd54: round_k = 64'h5b9cca4f7763e373;  7'd55: round_k = 64'h682e6ff3d6b2b8a3;
         7'd56: round_k = 64'h748f82ee5defb2fc;  7'd57: round_k = 64'h78a5636f43172f60;
         7'd58: round_k = 64'h84c87814a1f0ab72;  7'd59: round_k = 64'h8cc702081a6439ec;
         7'd60: round_k = 64'h90befffa23631e28;  7'd61: round_k = 64'ha4506cebde82bde9;
         7'd62: round_k = 64'hbef9a3f7b2c67915;  7'd63: round_k = 64'hc67178f2e372532b;
         7'd64: round_k = 64'hca273eceea26619c;  7'd65: round_k = 64'hd186b8c721c0c207;
         7'd66: round_k = 64'heada7dd6cde0eb1e;  7'd67: round_k = 64'hf57d4f7fee6ed178;
         7'd68: round_k = 64'h06f067aa72176fba;  7'd69: round_k = 64'h0a637dc5a2c898a6;
         7'd70: round_k = 64'h113f9804bef90dae;  7'd71: round_k = 64'h1b710b35131c471b;
         7'd72: round_k = 64'h28db77f523047d84;  7'd73: round_k = 64'h32caab7b40c72493;
         7'd74: round_k = 64'h3c9ebe0a15c9bebc;  7'd75: round_k = 64'h431d67c49c100d4c;
         7'd76: round_k = 64'h4cc5d4becb3e42b6;  7'd77: round_k = 64'h597f299cfc657e2a;
         7'd78: round_k = 64'h5fcb6fab3ad6faec;  7'd79: round_k = 64'h6c44198c4a475817;
         default: round_k = '0;
      endcase
   endfunction

endpackage

### rtl/sha512_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sha512_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/sha512_stream_hasher.sv
// SHA-512 stream hasher top level: byte absorption, padding, compression, digest output.
//
// Usage:
//  - Input channel (req_*): one transfer carries req_action and req_data_byte.
//    Action absorb appends req_data_byte to the message; action finish pads the
//    message, runs the last compression(s) and emits the digest.
//  - Result channel (rsp_*): eight transfers per finish, digest words 0..7 in
//    big-endian word order, rsp_last_word high on word 7.
//  - Throughput: one absorbed byte per cycle while req_stall is low. Each full
//    128-byte block then runs a compression (load, 80 rounds through one round
//    unit, final add), with req_stall high meanwhile.
//  - Finish: pad bytes are written from the fill point up to byte 112; with 16
//    or fewer free bytes the pad runs to byte 128, one compression follows and
//    112 more pad bytes; then two length-word writes, one compression, then
//    the eight result transfers.
//  - Message words live in a 16 x 64 RAM; rounds 0..15 read its registered output.
//  - Reset (synchronous, active high): chaining value back to the initial hash,
//    bit count and fill cleared, block idle and ready.
//  - A stall on the result channel holds the current word; no input is taken
//    until all eight words are transferred. After the last word the chaining
//    value returns to the initial hash for the next message.
module sha512_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_LEN0, S_LEN1, S_LOAD, S_RUN, S_ADD, S_OUT
   } state_type;

   // where to go once a compression is done
   typedef enum logic [1:0] { RET_IDLE, RET_PAD, RET_OUT } ret_type;

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;

   sha512_pkg::word_type cv_ff [sha512_pkg::NumCv];
   sha512_pkg::word_type cv_in [sha512_pkg::NumCv];
   sha512_pkg::word_type v_ff  [sha512_pkg::NumCv];
   sha512_pkg::word_type v_in  [sha512_pkg::NumCv];
   sha512_pkg::word_type w_ff  [16];
   sha512_pkg::word_type w_in  [16];

   logic [63:0] cnt_lo_ff, cnt_lo_in;
   logic [63:0] cnt_hi_ff, cnt_hi_in;
   logic [6:0]  fill_ff, fill_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        pad_first_ff, pad_first_in;
   logic [55:0] wbuf_ff, wbuf_in;

   logic        ram_we;
   logic [3:0]  ram_waddr;
   logic [63:0] ram_wdata;
   logic [3:0]  ram_raddr;
   logic [63:0] ram_rdata;

   logic [7:0]  ins_byte;
   logic [64:0] cnt_sum;
   sha512_pkg::word_type w_cur, t1, t2;

   sha512_ram #(.WIDTH(64), .DEPTH(16)) u_msg_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = cv_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

   // message schedule and round datapath
   always_comb begin
      if (rnd_ff < 7'd16) begin
         w_cur = ram_rdata;
      end else begin
         w_cur = sha512_pkg::ssig1(w_ff[14]) + w_ff[9] + sha512_pkg::ssig0(w_ff[1]) + w_ff[0];
      end
      t1 = v_ff[7] + sha512_pkg::bsig1(v_ff[4])
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha512_pkg::round_k(rnd_ff) + w_cur;
      t2 = sha512_pkg::bsig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign ins_byte = (state_ff == S_PAD) ? (pad_first_ff ? 8'h80 : 8'h00) : req_data_byte;
   assign cnt_sum  = {1'b0, cnt_lo_ff} + 65'd8;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cv_in        = cv_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      cnt_lo_in    = cnt_lo_ff;
      cnt_hi_in    = cnt_hi_ff;
      fill_in      = fill_ff;
      rnd_in       = rnd_ff;
      oidx_in      = oidx_ff;
      pad_first_in = pad_first_ff;
      wbuf_in      = wbuf_ff;
      ram_we       = 1'b0;
      ram_waddr    = fill_ff[6:3];
      ram_wdata    = {wbuf_ff, ins_byte};
      ram_raddr    = 4'd0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_action) begin
                  wbuf_in   = {wbuf_ff[47:0], ins_byte};
                  ram_we    = (fill_ff[2:0] == 3'd7);
                  fill_in   = fill_ff + 7'd1;
                  cnt_lo_in = cnt_sum[63:0];
                  cnt_hi_in = cnt_hi_ff + {63'd0, cnt_sum[64]};
                  if (fill_ff == 7'd127) begin
                     state_in = S_LOAD;
                     ret_in   = RET_IDLE;
                  end
               end else begin
                  state_in     = S_PAD;
                  pad_first_in = 1'b1;
               end
            end
         end
         S_PAD: begin
            wbuf_in      = {wbuf_ff[47:0], ins_byte};
            ram_we       = (fill_ff[2:0] == 3'd7);
            fill_in      = fill_ff + 7'd1;
            pad_first_in = 1'b0;
            if (fill_ff == 7'd127) begin
               state_in = S_LOAD;
               ret_in   = RET_PAD;
            end else if (fill_ff == 7'd111) begin
               state_in = S_LEN0;
            end
         end
         S_LEN0: begin
            ram_we    = 1'b1;
            ram_waddr = 4'd14;
            ram_wdata = cnt_hi_ff;
            state_in  = S_LEN1;
         end
         S_LEN1: begin
            ram_we    = 1'b1;
            ram_waddr = 4'd15;
            ram_wdata = cnt_lo_ff;
            fill_in   = '0;
            state_in  = S_LOAD;
            ret_in    = RET_OUT;
         end
         S_LOAD: begin
            ram_raddr = 4'd0;
            v_in      = cv_ff;
            rnd_in    = '0;
            state_in  = S_RUN;
         end
         S_RUN: begin
            ram_raddr = rnd_ff[3:0] + 4'd1;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = w_cur;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            if (rnd_ff == 7'(sha512_pkg::NumRnd - 1)) begin
               rnd_in   = '0;
               state_in = S_ADD;
            end else begin
               rnd_in = rnd_ff + 7'd1;
            end
         end
         S_ADD: begin
            for (int i = 0; i < sha512_pkg::NumCv; i++) begin
               cv_in[i] = cv_ff[i] + v_ff[i];
            end
            case (ret_ff)
               RET_PAD: state_in = S_PAD;
               RET_OUT: begin
                  state_in = S_OUT;
                  oidx_in  = '0;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < sha512_pkg::NumCv; i++) begin
                     cv_in[i] = sha512_pkg::init_value(3'(i));
                  end
                  cnt_lo_in = '0;
                  cnt_hi_in = '0;
                  fill_in   = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= RET_IDLE;
         cnt_lo_ff    <= '0;
         cnt_hi_ff    <= '0;
         fill_ff      <= '0;
         rnd_ff       <= '0;
         oidx_ff      <= '0;
         pad_first_ff <= 1'b0;
         for (int i = 0; i < sha512_pkg::NumCv; i++) begin
            cv_ff[i] <= sha512_pkg::init_value(3'(i));
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_lo_ff    <= cnt_lo_in;
         cnt_hi_ff    <= cnt_hi_in;
         fill_ff      <= fill_in;
         rnd_ff       <= rnd_in;
         oidx_ff      <= oidx_in;
         pad_first_ff <= pad_first_in;
         cv_ff        <= cv_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      w_ff    <= w_in;
      wbuf_ff <= wbuf_in;
   end

`ifndef SYNTHESIS
   a_no_input_while_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while digest pending");

   a_round_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (rnd_ff < 7'd80)) else $error("round counter overrun");

   a_round_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (rnd_ff == 7'd0)) else $error("round counter not cleared");

   a_clear_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=>
         (cnt_lo_ff == 64'd0 && cnt_hi_ff == 64'd0 && fill_ff == 7'd0 && state_ff == S_IDLE))
      else $error("state not cleared after digest");

   a_fill_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (fill_ff == cnt_lo_ff[9:3])) else $error("fill out of step");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the SHA-512 stream hasher with a built-in digest predictor.
module testbench;

   // action codes on the input channel
   localparam bit ActAbsorb = 1'b0;
   localparam bit ActFinish = 1'b1;

   localparam int QuietLimit = 20000;   // cycles without any transfer before giving up
   localparam int DrainCycles = 300;    // settle time after the last digest word
   localparam int RandItems = 350;      // input transfers in the random part

   localparam sha512_pkg::word_type RoundConst [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam sha512_pkg::word_type StartHash [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   // one input transfer; wait_empty makes the driver hold it back until every
   // digest word already predicted has been seen
   typedef struct {
      bit       action;
      bit [7:0] data;
      bit       wait_empty;
   } hash_req_type;

   typedef struct {
      sha512_pkg::word_type digest;
      bit [2:0]             index;
      bit                   last;
   } digest_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha512_stream_hasher u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   hash_req_type    pending_reqs[$];
   digest_word_type digest_q[$];
   hash_req_type    cur_req;
   int              errors = 0;
   int              req_gap = 0;
   int              rsp_gap = 0;
   int              quiet = 0;
   bit              calm = 1'b0;        // stretch with no idling on either side
   int              calm_left = 0;

   // predictor state
   sha512_pkg::word_type hash_state [8];
   bit [7:0]             msg_block [128];
   bit [127:0]           msg_bits;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic sha512_pkg::word_type rotr(sha512_pkg::word_type x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // mostly short gaps, now and then a long one; none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // 80-round compression of msg_block into hash_state
   task automatic fold_block();
      sha512_pkg::word_type w [16];
      sha512_pkg::word_type v [8];
      sha512_pkg::word_type wt, s0, s1, t1, t2;
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = '0;
            for (int i = 0; i < 8; i++)
               wt = (wt << 8) | sha512_pkg::word_type'(msg_block[t * 8 + i]);
         end else begin
            s1 = rotr(w[(t - 2) & 15], 19) ^ rotr(w[(t - 2) & 15], 61) ^ (w[(t - 2) & 15] >> 6);
            s0 = rotr(w[(t - 15) & 15], 1) ^ rotr(w[(t - 15) & 15], 8) ^ (w[(t - 15) & 15] >> 7);
            wt = s1 + w[(t - 7) & 15] + s0 + w[t & 15];
         end
         w[t & 15] = wt;
         t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + wt;
         t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endtask

   // apply one accepted request to the predictor; a finish queues eight words
   task automatic predict_hash(hash_req_type r);
      int fill;
      digest_word_type dw;
      fill = int'(msg_bits[9:3]);
      if (r.action == ActAbsorb) begin
         msg_block[fill] = r.data;
         msg_bits = msg_bits + 128'd8;
         if (fill == 127) fold_block();
      end else begin
         msg_block[fill] = 8'h80;
         fill++;
         if (fill > 112) begin
            while (fill < 128) begin msg_block[fill] = 8'h00; fill++; end
            fold_block();
            fill = 0;
         end
         while (fill < 112) begin msg_block[fill] = 8'h00; fill++; end
         for (int i = 0; i < 16; i++) msg_block[112 + i] = msg_bits[127 - 8 * i -: 8];
         fold_block();
         for (int i = 0; i < 8; i++) begin
            dw.digest = hash_state[i];
            dw.index  = 3'(i);
            dw.last   = (i == 7);
            digest_q.push_back(dw);
         end
         for (int i = 0; i < 8; i++) hash_state[i] = StartHash[i];
         msg_bits = '0;
      end
   endtask

   task automatic add_req(bit action, bit [7:0] data, bit wait_empty);
      hash_req_type r;
      r.action = action;
      r.data = data;
      r.wait_empty = wait_empty;
      pending_reqs.push_back(r);
   endtask

   // one message: len random bytes, then a finish carrying a random ignored byte
   task automatic add_message(int len, bit wait_empty);
      for (int i = 0; i < len; i++) add_req(ActAbsorb, 8'($urandom), (i == 0) && wait_empty);
      add_req(ActFinish, 8'($urandom), (len == 0) && wait_empty);
   endtask

   // driver: predicts on each accepted transfer, then loads the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_action <= ActAbsorb;
         req_data_byte <= 8'h00;
      end else begin
         if (req_valid && !req_stall) predict_hash(cur_req);
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].wait_empty || digest_q.size() == 0)) begin
               cur_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_action <= cur_req.action;
               req_data_byte <= cur_req.data;
               req_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random result stall and in-order comparison of digest words
   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $error("digest word %h with no prediction waiting", rsp_digest_word);
               errors++;
            end else begin
               exp_w = digest_q.pop_front();
               if (rsp_digest_word !== exp_w.digest) begin
                  $error("digest_word expected %h actual %h", exp_w.digest, rsp_digest_word);
                  errors++;
               end
               if (rsp_word_index !== exp_w.index) begin
                  $error("word_index expected %0d actual %0d", exp_w.index, rsp_word_index);
                  errors++;
               end
               if (rsp_last_word !== exp_w.last) begin
                  $error("last_word expected %0d actual %0d", exp_w.last, rsp_last_word);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_gap = pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // alternate between idle-free stretches and stretches with random idling
   always @(posedge clock) begin
      if (calm_left > 0) begin
         calm_left--;
      end else begin
         calm = ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(50, 400);
      end
   end

   // watchdog on transfers of either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QuietLimit) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int n_items;
      int len;
      reset = 1'b1;
      for (int i = 0; i < 8; i++) hash_state[i] = StartHash[i];
      msg_bits = '0;

      // directed: empty message, ignored byte on finish, extreme bytes, "abc"
      add_req(ActFinish, 8'h00, 1'b0);
      add_req(ActFinish, 8'hff, 1'b0);
      add_req(ActAbsorb, 8'h00, 1'b0);
      add_req(ActFinish, 8'h00, 1'b0);
      add_req(ActAbsorb, 8'hff, 1'b0);
      add_req(ActFinish, 8'h5a, 1'b0);
      add_req(ActAbsorb, 8'h61, 1'b0);
      add_req(ActAbsorb, 8'h62, 1'b0);
      add_req(ActAbsorb, 8'h63, 1'b0);
      add_req(ActFinish, 8'ha5, 1'b0);

      // random messages: mostly short, some at the padding and block boundaries
      // (room for length, extra pad block, exact block, several blocks)
      n_items = 0;
      while (n_items < RandItems) begin
         if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 6))
               0: len = 111;
               1: len = 112;
               2: len = 127;
               3: len = 128;
               4: len = 129;
               5: len = 239;
               default: len = 256;
            endcase
         end else begin
            len = $urandom_range(0, 20);
         end
         // keep the total near the item budget, finish included
         if (len > RandItems - 1 - n_items) len = RandItems - 1 - n_items;
         // the first random message always waits for the directed digests to drain
         add_message(len, (n_items == 0) || ($urandom_range(0, 9) == 0));
         n_items += len + 1;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0);
      do @(posedge clock); while (req_valid || digest_q.size() != 0);
      repeat (DrainCycles) @(posedge clock);

      if (errors == 0 && digest_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
